// ----- design/msp_pkg.sv -----
package msp_pkg;

  // field widths fixed by the interface
  localparam int NOW_W   = 40;
  localparam int WALL_W  = 32;
  localparam int CMD_W   = 4;
  localparam int ARG_W   = 8;
  localparam int DUTY_W  = 7;
  localparam int SEC_W   = 16;
  localparam int MS_W    = 26;  // 65535 s * 1000 fits in 26 bits
  localparam int EV_W    = 7;
  localparam int CFG_W   = 16;
  localparam int CIDX_W  = 2;

  localparam int TIME_BITS_DEF = 40;

  localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_AUTO_DUTY  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_DISPERSE_S = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_MEMBRANE_S = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_WAIT_S     = 2'd3;

  // configuration reset values
  localparam logic [DUTY_W-1:0] AUTO_DUTY_RST  = 7'd50;
  localparam logic [SEC_W-1:0]  DISPERSE_S_RST = 16'd30;
  localparam logic [SEC_W-1:0]  MEMBRANE_S_RST = 16'd30;
  localparam logic [SEC_W-1:0]  WAIT_S_RST     = 16'd60;

  localparam logic [MS_W-1:0] MS_PER_S = 26'd1000;

  typedef enum logic [2:0] {
    PH_INIT    = 3'd0,
    PH_STANDBY = 3'd1,
    PH_RUNNING = 3'd2,
    PH_ADISP   = 3'd3,
    PH_AMEMB   = 3'd4,
    PH_AWAIT   = 3'd5,
    PH_TERM    = 3'd6,
    PH_SAFE    = 3'd7
  } phase_t;

  // ground command codes
  localparam logic [CMD_W-1:0] CMD_ECHO       = 4'd0;
  localparam logic [CMD_W-1:0] CMD_ARM        = 4'd1;
  localparam logic [CMD_W-1:0] CMD_PAUSE      = 4'd2;
  localparam logic [CMD_W-1:0] CMD_CONTINUE   = 4'd3;
  localparam logic [CMD_W-1:0] CMD_TERMINATE  = 4'd4;
  localparam logic [CMD_W-1:0] CMD_LAUNCH     = 4'd5;
  localparam logic [CMD_W-1:0] CMD_FIRE_VALVE = 4'd6;
  localparam logic [CMD_W-1:0] CMD_MEMB_DUTY  = 4'd7;
  localparam logic [CMD_W-1:0] CMD_MOTOR      = 4'd8;
  localparam logic [CMD_W-1:0] CMD_SETPARAM   = 4'd9;
  localparam logic [CMD_W-1:0] CMD_STATUS     = 4'd10;

  // disperse command modes
  localparam logic [ARG_W-1:0] DISP_STOP  = 8'd0;
  localparam logic [ARG_W-1:0] DISP_PULSE = 8'd1;
  localparam logic [ARG_W-1:0] DISP_RUN   = 8'd2;

  // release valve numbers
  localparam logic [ARG_W-1:0] VALVE_A = 8'd1;
  localparam logic [ARG_W-1:0] VALVE_B = 8'd2;

  // event flag bit positions
  localparam int EV_STATE    = 0;
  localparam int EV_AUTO_IN  = 1;
  localparam int EV_AUTO_OUT = 2;
  localparam int EV_RELEASE  = 3;
  localparam int EV_SELFTEST = 4;
  localparam int EV_ABORT    = 5;
  localparam int EV_MANUAL   = 6;

  typedef struct packed {
    logic [2:0]        phase;
    logic [DUTY_W-1:0] membrane_level;
    logic              motor_on;
    logic              motor_relatch;
    logic [1:0]        fire_valve;
    logic [1:0]        fired_valves;
    logic              disperse_pulse;
    logic              close_valves;
    logic              nack;
    logic [EV_W-1:0]   event_flags;
    logic              persist_req;
  } res_t;

  function automatic logic [MS_W-1:0] secs_to_ms(input logic [SEC_W-1:0] s);
    secs_to_ms = MS_W'(s) * MS_PER_S;
  endfunction

  function automatic logic [DUTY_W-1:0] sat_duty(input logic [DUTY_W-1:0] d);
    sat_duty = (d > DUTY_MAX) ? DUTY_MAX : d;
  endfunction

endpackage

// ----- design/mission_phase_sequencer.sv -----
// mission_phase_sequencer: phase sequencer of a flight experiment. Each input
// transaction is either a periodic tick (op 0) that advances the phase machine
// (init, standby, running, automatic disperse / membrane / wait cycle,
// termination, safe) or a ground command (op 1) that first leaves the
// automatic cycle and then executes. Every transaction gives exactly one
// result carrying the phase, the actuator levels and the per-transaction event
// flags. A transaction is captured in an input register and its result is
// then written to the result register, so a new transaction is taken every
// cycle as long as the result side keeps up; the result register lets the
// next transaction enter while a result waits. Phase lengths are converted
// from seconds to milliseconds when the configuration registers are written,
// so a tick only needs one time subtraction and one compare. Configuration
// writes take effect on the next transaction and must be made while the
// block is idle.
module mission_phase_sequencer #(
  parameter int TIME_BITS = msp_pkg::TIME_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,

  // configuration write port
  input  logic                        cfg_we,
  input  logic [msp_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [msp_pkg::CFG_W-1:0]   cfg_data,

  // input transaction
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        op,
  input  logic [msp_pkg::NOW_W-1:0]   now_ms,
  input  logic [msp_pkg::WALL_W-1:0]  wall_s,
  input  logic                        link_lost,
  input  logic                        self_test_ok,
  input  logic [msp_pkg::CMD_W-1:0]   command,
  input  logic [msp_pkg::ARG_W-1:0]   argument,
  input  logic                        param_ok,
  input  logic                        param_is_disperse_duty,

  // result transaction
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  phase,
  output logic [msp_pkg::DUTY_W-1:0]  membrane_level,
  output logic                        motor_on,
  output logic                        motor_relatch,
  output logic [1:0]                  fire_valve,
  output logic [1:0]                  fired_valves,
  output logic                        disperse_pulse,
  output logic                        close_valves,
  output logic                        nack,
  output logic [msp_pkg::EV_W-1:0]    event_flags,
  output logic                        persist_req
);

  // configuration, held in the form the datapath wants
  logic [msp_pkg::DUTY_W-1:0] auto_duty;     // already saturated to 100
  logic [msp_pkg::MS_W-1:0]   disperse_ms;
  logic [msp_pkg::MS_W-1:0]   membrane_ms;
  logic [msp_pkg::MS_W-1:0]   wait_ms;

  // input register
  logic                        s_valid;
  logic                        s_op;
  logic [TIME_BITS-1:0]        s_now;
  logic [msp_pkg::WALL_W-1:0]  s_wall;
  logic                        s_link;
  logic                        s_st_ok;
  logic [msp_pkg::CMD_W-1:0]   s_cmd;
  logic [msp_pkg::ARG_W-1:0]   s_arg;
  logic                        s_pok;
  logic                        s_pduty;

  // sequencer state
  msp_pkg::phase_t             phase_reg, phase_next;
  logic [TIME_BITS-1:0]        phase_start_ms, phase_start_ms_next;
  logic [1:0]                  fired_mask, fired_mask_next;
  logic [msp_pkg::WALL_W-1:0]  mission_start, mission_start_next;
  logic                        hold_flag, hold_flag_next;
  logic                        motor_flag, motor_flag_next;
  logic [msp_pkg::DUTY_W-1:0]  membrane_reg, membrane_reg_next;

  // per-transaction flags
  logic                        go;          // phase entered, timestamp taken
  logic                        relatch_c;
  logic [1:0]                  fire_c;
  logic                        pulse_c;
  logic                        close_c;
  logic                        inval_c;
  logic [msp_pkg::EV_W-1:0]    ev_c;

  // result register
  logic                        r_valid;
  msp_pkg::res_t               r_res, res_next;

  logic                        advance;
  logic                        in_auto;
  logic [TIME_BITS-1:0]        elapsed;
  logic [msp_pkg::MS_W-1:0]    len_ms;
  logic                        timed_out;
  logic [1:0]                  valve_bit;

  // handshake: the input register moves on whenever the result register
  // is empty or being drained in this cycle
  assign advance  = s_valid && (!r_valid || out_ready);
  assign in_ready = !s_valid || advance;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      auto_duty   <= msp_pkg::AUTO_DUTY_RST;
      disperse_ms <= msp_pkg::secs_to_ms(msp_pkg::DISPERSE_S_RST);
      membrane_ms <= msp_pkg::secs_to_ms(msp_pkg::MEMBRANE_S_RST);
      wait_ms     <= msp_pkg::secs_to_ms(msp_pkg::WAIT_S_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        msp_pkg::CFG_AUTO_DUTY:
          auto_duty <= msp_pkg::sat_duty(cfg_data[msp_pkg::DUTY_W-1:0]);
        msp_pkg::CFG_DISPERSE_S:
          disperse_ms <= msp_pkg::secs_to_ms(cfg_data[msp_pkg::SEC_W-1:0]);
        msp_pkg::CFG_MEMBRANE_S:
          membrane_ms <= msp_pkg::secs_to_ms(cfg_data[msp_pkg::SEC_W-1:0]);
        msp_pkg::CFG_WAIT_S:
          wait_ms <= msp_pkg::secs_to_ms(cfg_data[msp_pkg::SEC_W-1:0]);
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_op    <= op;
      s_now   <= TIME_BITS'(now_ms);   // elapsed time wraps at TIME_BITS
      s_wall  <= wall_s;
      s_link  <= link_lost;
      s_st_ok <= self_test_ok;
      s_cmd   <= command;
      s_arg   <= argument;
      s_pok   <= param_ok;
      s_pduty <= param_is_disperse_duty;
    end
  end

  // automatic phase timeout: one subtract and one compare
  assign in_auto = phase_reg inside {msp_pkg::PH_ADISP, msp_pkg::PH_AMEMB,
                                     msp_pkg::PH_AWAIT};
  assign elapsed = s_now - phase_start_ms;

  always_comb begin
    case (phase_reg)
      msp_pkg::PH_ADISP: len_ms = disperse_ms;
      msp_pkg::PH_AMEMB: len_ms = membrane_ms;
      default:           len_ms = wait_ms;
    endcase
  end

  assign timed_out = elapsed >= TIME_BITS'(len_ms);
  assign valve_bit = (s_arg == msp_pkg::VALVE_A) ? 2'b01 : 2'b10;

  // next state of the sequencer
  always_comb begin
    phase_next          = phase_reg;
    phase_start_ms_next = phase_start_ms;
    fired_mask_next     = fired_mask;
    mission_start_next  = mission_start;
    hold_flag_next      = hold_flag;
    motor_flag_next     = motor_flag;
    membrane_reg_next   = membrane_reg;
    go        = 1'b0;
    relatch_c = 1'b0;
    fire_c    = 2'd0;
    pulse_c   = 1'b0;
    close_c   = 1'b0;
    inval_c   = 1'b0;
    ev_c      = '0;

    if (!s_op) begin
      // periodic tick
      case (phase_reg)
        msp_pkg::PH_INIT: begin
          go = 1'b1;
          if (s_st_ok) begin
            phase_next = msp_pkg::PH_STANDBY;
          end else begin
            ev_c[msp_pkg::EV_SELFTEST] = 1'b1;
            phase_next = msp_pkg::PH_SAFE;
          end
        end
        msp_pkg::PH_RUNNING: begin
          if (!hold_flag && s_link) begin
            ev_c[msp_pkg::EV_AUTO_IN] = 1'b1;
            phase_next        = msp_pkg::PH_ADISP;
            motor_flag_next   = 1'b1;
            relatch_c         = 1'b1;
            membrane_reg_next = '0;
            go                = 1'b1;
          end
        end
        msp_pkg::PH_ADISP, msp_pkg::PH_AMEMB, msp_pkg::PH_AWAIT: begin
          if (!s_link) begin
            // link came back: drop out of the cycle
            motor_flag_next   = 1'b0;
            membrane_reg_next = '0;
            ev_c[msp_pkg::EV_AUTO_OUT] = 1'b1;
            phase_next        = msp_pkg::PH_RUNNING;
            go                = 1'b1;
          end else if (timed_out) begin
            go = 1'b1;
            case (phase_reg)
              msp_pkg::PH_ADISP: begin
                phase_next        = msp_pkg::PH_AMEMB;
                motor_flag_next   = 1'b0;
                membrane_reg_next = auto_duty;
              end
              msp_pkg::PH_AMEMB: begin
                phase_next        = msp_pkg::PH_AWAIT;
                motor_flag_next   = 1'b0;
                membrane_reg_next = '0;
              end
              default: begin
                phase_next        = msp_pkg::PH_ADISP;
                motor_flag_next   = 1'b1;
                relatch_c         = 1'b1;
                membrane_reg_next = '0;
              end
            endcase
          end
        end
        msp_pkg::PH_TERM: begin
          membrane_reg_next = '0;
          motor_flag_next   = 1'b0;
          close_c           = 1'b1;
          phase_next        = msp_pkg::PH_SAFE;
          go                = 1'b1;
        end
        default: ;
      endcase
    end else begin
      // ground command: any command leaves the automatic cycle first
      if (in_auto) begin
        motor_flag_next   = 1'b0;
        membrane_reg_next = '0;
        ev_c[msp_pkg::EV_AUTO_OUT] = 1'b1;
        phase_next        = msp_pkg::PH_RUNNING;
        go                = 1'b1;
      end
      case (s_cmd)
        msp_pkg::CMD_ECHO, msp_pkg::CMD_ARM, msp_pkg::CMD_STATUS: ;
        msp_pkg::CMD_PAUSE:    hold_flag_next = 1'b1;
        msp_pkg::CMD_CONTINUE: hold_flag_next = 1'b0;
        msp_pkg::CMD_TERMINATE: begin
          ev_c[msp_pkg::EV_ABORT] = 1'b1;
          hold_flag_next = 1'b0;
          if (phase_next != msp_pkg::PH_SAFE) begin
            phase_next = msp_pkg::PH_TERM;
            go         = 1'b1;
          end
        end
        msp_pkg::CMD_LAUNCH: begin
          hold_flag_next = 1'b0;
          if (mission_start == '0) begin
            mission_start_next = s_wall;
          end
          if (phase_next != msp_pkg::PH_RUNNING) begin
            phase_next = msp_pkg::PH_RUNNING;
            go         = 1'b1;
          end
        end
        msp_pkg::CMD_FIRE_VALVE: begin
          if (!(s_arg inside {msp_pkg::VALVE_A, msp_pkg::VALVE_B})) begin
            inval_c = 1'b1;
          end else begin
            if (phase_next inside {msp_pkg::PH_TERM, msp_pkg::PH_SAFE}) begin
              phase_next = msp_pkg::PH_RUNNING;
              go         = 1'b1;
            end
            // a valve fires once per mission
            if ((fired_mask & valve_bit) == 2'b00) begin
              fired_mask_next = fired_mask | valve_bit;
              fire_c          = s_arg[1:0];
              pulse_c         = !motor_flag_next;
              ev_c[msp_pkg::EV_RELEASE] = 1'b1;
            end
          end
        end
        msp_pkg::CMD_MEMB_DUTY: begin
          if (s_arg > msp_pkg::ARG_W'(msp_pkg::DUTY_MAX)) begin
            inval_c = 1'b1;
          end else begin
            if (phase_next inside {msp_pkg::PH_TERM, msp_pkg::PH_SAFE}) begin
              phase_next = msp_pkg::PH_RUNNING;
              go         = 1'b1;
            end
            membrane_reg_next = s_arg[msp_pkg::DUTY_W-1:0];
            ev_c[msp_pkg::EV_MANUAL] = 1'b1;
          end
        end
        msp_pkg::CMD_MOTOR: begin
          if (s_arg > msp_pkg::DISP_RUN) begin
            inval_c = 1'b1;
          end else if (s_arg == msp_pkg::DISP_STOP) begin
            motor_flag_next = 1'b0;
            ev_c[msp_pkg::EV_MANUAL] = 1'b1;
          end else begin
            if (phase_next inside {msp_pkg::PH_TERM, msp_pkg::PH_SAFE}) begin
              phase_next = msp_pkg::PH_RUNNING;
              go         = 1'b1;
            end
            if (s_arg == msp_pkg::DISP_RUN) begin
              motor_flag_next = 1'b1;
              relatch_c       = 1'b1;
            end else if (!motor_flag_next) begin
              pulse_c = 1'b1;   // pulse only when the motor is not held on
            end
            ev_c[msp_pkg::EV_MANUAL] = 1'b1;
          end
        end
        msp_pkg::CMD_SETPARAM: begin
          if (!s_pok) begin
            inval_c = 1'b1;
          end else if (s_pduty && motor_flag_next) begin
            relatch_c = 1'b1;   // running motor picks up the new speed
          end
        end
        default: inval_c = 1'b1;
      endcase
    end

    // any phase entry stamps the time and asks for a durable record
    if (go) begin
      phase_start_ms_next = s_now;
      ev_c[msp_pkg::EV_STATE] = 1'b1;
    end
  end

  // result fields
  always_comb begin
    res_next.phase          = phase_next;
    res_next.membrane_level = membrane_reg_next;
    res_next.motor_on       = motor_flag_next;
    res_next.motor_relatch  = relatch_c;
    res_next.fire_valve     = fire_c;
    res_next.fired_valves   = fired_mask_next;
    res_next.disperse_pulse = pulse_c;
    res_next.close_valves   = close_c;
    res_next.nack           = inval_c;
    res_next.event_flags    = ev_c;
    res_next.persist_req    = go || (fire_c != 2'd0);
  end

  // state update, one transaction at a time in order
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg      <= msp_pkg::PH_INIT;
      phase_start_ms <= '0;
      fired_mask     <= '0;
      mission_start  <= '0;
      hold_flag      <= 1'b0;
      motor_flag     <= 1'b0;
      membrane_reg   <= '0;
    end else if (advance) begin
      phase_reg      <= phase_next;
      phase_start_ms <= phase_start_ms_next;
      fired_mask     <= fired_mask_next;
      mission_start  <= mission_start_next;
      hold_flag      <= hold_flag_next;
      motor_flag     <= motor_flag_next;
      membrane_reg   <= membrane_reg_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (advance) begin
      r_valid <= 1'b1;
    end else if (out_ready) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      r_res <= res_next;
    end
  end

  assign out_valid      = r_valid;
  assign phase          = r_res.phase;
  assign membrane_level = r_res.membrane_level;
  assign motor_on       = r_res.motor_on;
  assign motor_relatch  = r_res.motor_relatch;
  assign fire_valve     = r_res.fire_valve;
  assign fired_valves   = r_res.fired_valves;
  assign disperse_pulse = r_res.disperse_pulse;
  assign close_valves   = r_res.close_valves;
  assign nack           = r_res.nack;
  assign event_flags    = r_res.event_flags;
  assign persist_req    = r_res.persist_req;

  // a relatch always leaves the motor running
  a_relatch_motor: assert property (@(posedge clk) disable iff (rst)
    out_valid && motor_relatch |-> motor_on)
    else $error("relatch without motor on");

  // closing the valves only happens on the way into safe with actuators off
  a_close_safe: assert property (@(posedge clk) disable iff (rst)
    out_valid && close_valves |->
      phase == msp_pkg::PH_SAFE && !motor_on && membrane_level == '0)
    else $error("valves closed outside termination");

  // a fired valve is recorded in the mask of the same result
  a_fire_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid && fire_valve != 2'd0 |->
      (fire_valve == 2'd1 && fired_valves[0]) || (fire_valve == 2'd2 && fired_valves[1]))
    else $error("fired valve missing from mask");

  // every phase change asks for a durable record
  a_state_persist: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_flags[msp_pkg::EV_STATE] |-> persist_req)
    else $error("phase change without persist request");

  // a stalled transaction stays in the input register
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s_valid && !advance |=> s_valid)
    else $error("input register lost a transaction");

endmodule

// ----- verif/tb_mission_phase_sequencer.sv -----
module tb_mission_phase_sequencer;
  import msp_pkg::*;

  // transaction kinds on the op field
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_COMMAND = 1'b1;

  // codes and arguments outside the legal sets
  localparam logic [CMD_W-1:0] CMD_UNDEFINED = 4'hF;
  localparam logic [ARG_W-1:0] NO_VALVE      = 8'd0;
  localparam logic [ARG_W-1:0] DISP_BAD      = 8'd3;
  localparam logic [ARG_W-1:0] DUTY_OVER     = 8'd101;

  localparam logic [NOW_W-1:0] MS_PER_SECOND = 40'd1000;

  localparam int ITEMS_PER_SETTING = 112;
  localparam int DRAIN_CYCLES      = 4;     // drains the input and result registers, plus margin
  localparam int STALL_LIMIT       = 1000;  // cycles with no transaction at all

  // one input transaction as the sender sees it
  typedef struct {
    logic              op;
    logic [NOW_W-1:0]  now_ms;
    logic [WALL_W-1:0] wall_s;
    logic              link_lost;
    logic              self_test_ok;
    logic [CMD_W-1:0]  command;
    logic [ARG_W-1:0]  argument;
    logic              param_ok;
    logic              param_is_disperse_duty;
  } item_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [CIDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic              op;
  logic [NOW_W-1:0]  now_ms;
  logic [WALL_W-1:0] wall_s;
  logic              link_lost;
  logic              self_test_ok;
  logic [CMD_W-1:0]  command;
  logic [ARG_W-1:0]  argument;
  logic              param_ok;
  logic              param_is_disperse_duty;
  logic              out_valid;
  logic              out_ready;
  logic [2:0]        phase;
  logic [DUTY_W-1:0] membrane_level;
  logic              motor_on;
  logic              motor_relatch;
  logic [1:0]        fire_valve;
  logic [1:0]        fired_valves;
  logic              disperse_pulse;
  logic              close_valves;
  logic              nack;
  logic [EV_W-1:0]   event_flags;
  logic              persist_req;

  mission_phase_sequencer dut (.*);

  // sequencer state as predicted from accepted transactions
  phase_t            pr_phase         = PH_INIT;
  logic [NOW_W-1:0]  pr_phase_start   = '0;
  logic [1:0]        pr_fired         = '0;
  logic [WALL_W-1:0] pr_mission_start = '0;
  logic              pr_hold          = 1'b0;
  logic              pr_motor         = 1'b0;
  logic [DUTY_W-1:0] pr_membrane      = '0;

  // register values as last written
  logic [DUTY_W-1:0] cf_auto_duty  = AUTO_DUTY_RST;
  logic [SEC_W-1:0]  cf_disperse_s = DISPERSE_S_RST;
  logic [SEC_W-1:0]  cf_membrane_s = MEMBRANE_S_RST;
  logic [SEC_W-1:0]  cf_wait_s     = WAIT_S_RST;

  res_t outcome;                 // result being built for the current transaction
  res_t expected_results[$];     // predicted results, oldest first

  logic [NOW_W-1:0] mission_ms = '0;  // running time base for the stimulus

  int   fail_count      = 0;
  int   items_sent      = 0;
  int   results_checked = 0;
  int   settings_used   = 0;
  int   quiet_cycles    = 0;
  logic [7:0] phases_seen = '0;

  // idle stretches: each side picks at random between calm runs and runs of random gaps
  int in_left  = 0;
  bit in_calm  = 0;
  int out_left = 0;
  bit out_calm = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int draw_wait(inout int left, inout bit calm);
    if (left == 0) begin
      left = int'($urandom_range(8, 40));
      calm = ($urandom_range(0, 3) == 0);
    end
    left--;
    return calm ? 0 : int'($urandom_range(0, 7));
  endfunction

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic logic in_cycle();
    return pr_phase == PH_ADISP || pr_phase == PH_AMEMB || pr_phase == PH_AWAIT;
  endfunction

  // length of the current automatic phase in ms
  function automatic logic [NOW_W-1:0] span_ms();
    logic [SEC_W-1:0] secs;
    case (pr_phase)
      PH_ADISP: secs = cf_disperse_s;
      PH_AMEMB: secs = cf_membrane_s;
      default:  secs = cf_wait_s;
    endcase
    return NOW_W'(secs) * MS_PER_SECOND;
  endfunction

  function automatic void set_motor(input logic on);
    pr_motor = on;
    if (on) outcome.motor_relatch = 1'b1;
  endfunction

  function automatic void enter_phase(input phase_t ph, input logic [NOW_W-1:0] t);
    pr_phase       = ph;
    pr_phase_start = t;
    outcome.persist_req = 1'b1;
    outcome.event_flags[EV_STATE] = 1'b1;
  endfunction

  function automatic void start_auto_phase(input phase_t ph, input logic [NOW_W-1:0] t);
    set_motor(ph == PH_ADISP);
    // oversized auto duty saturates
    if (ph == PH_AMEMB)
      pr_membrane = (cf_auto_duty > DUTY_MAX) ? DUTY_MAX : cf_auto_duty;
    else
      pr_membrane = '0;
    enter_phase(ph, t);
  endfunction

  function automatic void quit_cycle(input logic [NOW_W-1:0] t);
    set_motor(1'b0);
    pr_membrane = '0;
    outcome.event_flags[EV_AUTO_OUT] = 1'b1;
    enter_phase(PH_RUNNING, t);
  endfunction

  // manual actuator commands bring the machine back from termination or safe
  function automatic void wake_up(input logic [NOW_W-1:0] t);
    if (pr_phase == PH_TERM || pr_phase == PH_SAFE) enter_phase(PH_RUNNING, t);
  endfunction

  function automatic res_t predict_result(input item_t it);
    logic [NOW_W-1:0] t;
    logic [1:0]       valve_bit;
    phase_t           nxt;
    t = it.now_ms;
    outcome = '0;
    if (it.op == OP_TICK) begin
      case (pr_phase)
        PH_INIT: begin
          if (it.self_test_ok) begin
            enter_phase(PH_STANDBY, t);
          end else begin
            outcome.event_flags[EV_SELFTEST] = 1'b1;
            enter_phase(PH_SAFE, t);
          end
        end
        PH_RUNNING: begin
          if (!pr_hold && it.link_lost) begin
            outcome.event_flags[EV_AUTO_IN] = 1'b1;
            start_auto_phase(PH_ADISP, t);
          end
        end
        PH_ADISP, PH_AMEMB, PH_AWAIT: begin
          if (!it.link_lost) begin
            quit_cycle(t);
          end else if (t - pr_phase_start >= span_ms()) begin
            // elapsed time wraps with the time base
            case (pr_phase)
              PH_ADISP: nxt = PH_AMEMB;
              PH_AMEMB: nxt = PH_AWAIT;
              default:  nxt = PH_ADISP;
            endcase
            start_auto_phase(nxt, t);
          end
        end
        PH_TERM: begin
          pr_membrane = '0;
          set_motor(1'b0);
          outcome.close_valves = 1'b1;
          enter_phase(PH_SAFE, t);
        end
        default: ;
      endcase
    end else begin
      // any command, even an unknown one, leaves the automatic cycle first
      if (in_cycle()) quit_cycle(t);
      case (it.command)
        CMD_ECHO, CMD_ARM, CMD_STATUS: ;
        CMD_PAUSE:    pr_hold = 1'b1;
        CMD_CONTINUE: pr_hold = 1'b0;
        CMD_TERMINATE: begin
          outcome.event_flags[EV_ABORT] = 1'b1;
          pr_hold = 1'b0;
          if (pr_phase != PH_SAFE) enter_phase(PH_TERM, t);
        end
        CMD_LAUNCH: begin
          pr_hold = 1'b0;
          if (pr_mission_start == '0) pr_mission_start = it.wall_s;
          if (pr_phase != PH_RUNNING) enter_phase(PH_RUNNING, t);
        end
        CMD_FIRE_VALVE: begin
          if (it.argument != VALVE_A && it.argument != VALVE_B) begin
            outcome.nack = 1'b1;
          end else begin
            wake_up(t);
            valve_bit = (it.argument == VALVE_A) ? 2'b01 : 2'b10;
            // a valve already fired answers ok and does nothing
            if ((pr_fired & valve_bit) == '0) begin
              pr_fired = pr_fired | valve_bit;
              outcome.persist_req = 1'b1;
              outcome.fire_valve  = it.argument[1:0];
              if (!pr_motor) outcome.disperse_pulse = 1'b1;
              outcome.event_flags[EV_RELEASE] = 1'b1;
            end
          end
        end
        CMD_MEMB_DUTY: begin
          if (it.argument > DUTY_MAX) begin
            outcome.nack = 1'b1;
          end else begin
            wake_up(t);
            pr_membrane = it.argument[DUTY_W-1:0];
            outcome.event_flags[EV_MANUAL] = 1'b1;
          end
        end
        CMD_MOTOR: begin
          if (it.argument > DISP_RUN) begin
            outcome.nack = 1'b1;
          end else if (it.argument == DISP_STOP) begin
            set_motor(1'b0);
            outcome.event_flags[EV_MANUAL] = 1'b1;
          end else begin
            wake_up(t);
            if (it.argument == DISP_RUN) set_motor(1'b1);
            else if (!pr_motor) outcome.disperse_pulse = 1'b1;
            outcome.event_flags[EV_MANUAL] = 1'b1;
          end
        end
        CMD_SETPARAM: begin
          if (!it.param_ok) outcome.nack = 1'b1;
          else if (it.param_is_disperse_duty && pr_motor) set_motor(1'b1);
        end
        default: outcome.nack = 1'b1;
      endcase
    end
    outcome.phase          = pr_phase;
    outcome.membrane_level = pr_membrane;
    outcome.motor_on       = pr_motor;
    outcome.fired_valves   = pr_fired;
    return outcome;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stalls and the field-by-field check
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = draw_wait(out_left, out_calm);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1 || rst);
    end
  end

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with no prediction pending");
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        compare_field("phase",          8'(want.phase),          8'(phase));
        compare_field("membrane_level", 8'(want.membrane_level), 8'(membrane_level));
        compare_field("motor_on",       8'(want.motor_on),       8'(motor_on));
        compare_field("motor_relatch",  8'(want.motor_relatch),  8'(motor_relatch));
        compare_field("fire_valve",     8'(want.fire_valve),     8'(fire_valve));
        compare_field("fired_valves",   8'(want.fired_valves),   8'(fired_valves));
        compare_field("disperse_pulse", 8'(want.disperse_pulse), 8'(disperse_pulse));
        compare_field("close_valves",   8'(want.close_valves),   8'(close_valves));
        compare_field("nack",           8'(want.nack),           8'(nack));
        compare_field("event_flags",    8'(want.event_flags),    8'(event_flags));
        compare_field("persist_req",    8'(want.persist_req),    8'(persist_req));
        results_checked++;
        phases_seen[phase] <= 1'b1;
      end
    end
  end

  // watchdog: a long run of cycles with no transaction means a hang
  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $error("no transaction for %0d cycles", STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // valid stays high between back-to-back transactions, dropped only for a gap
  task automatic send_item(input item_t it);
    int gap;
    gap = draw_wait(in_left, in_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid               <= 1'b1;
    op                     <= it.op;
    now_ms                 <= it.now_ms;
    wall_s                 <= it.wall_s;
    link_lost              <= it.link_lost;
    self_test_ok           <= it.self_test_ok;
    command                <= it.command;
    argument               <= it.argument;
    param_ok               <= it.param_ok;
    param_is_disperse_duty <= it.param_is_disperse_duty;
    do @(posedge clk); while (in_ready !== 1'b1);
    expected_results.push_back(predict_result(it));
    items_sent++;
  endtask

  // random payload on every field the caller does not pin down, but the time follows mission_ms
  function automatic item_t base_item(input logic kind);
    item_t it;
    it.op                     = kind;
    it.now_ms                 = mission_ms;
    it.wall_s                 = $urandom();
    it.link_lost              = 1'($urandom_range(0, 1));
    it.self_test_ok           = 1'($urandom_range(0, 1));
    it.command                = 4'($urandom_range(0, 15));
    it.argument               = 8'($urandom_range(0, 255));
    it.param_ok               = 1'($urandom_range(0, 1));
    it.param_is_disperse_duty = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic send_tick(input logic link, input logic [NOW_W-1:0] at);
    item_t it;
    mission_ms = at;
    it = base_item(OP_TICK);
    it.link_lost = link;
    send_item(it);
  endtask

  task automatic send_cmd(input logic [CMD_W-1:0] code, input logic [ARG_W-1:0] arg);
    item_t it;
    mission_ms = mission_ms + NOW_W'($urandom_range(0, 50));
    it = base_item(OP_COMMAND);
    it.command  = code;
    it.argument = arg;
    send_item(it);
  endtask

  task automatic send_param(input logic accepted, input logic is_duty);
    item_t it;
    it = base_item(OP_COMMAND);
    it.command                = CMD_SETPARAM;
    it.param_ok               = accepted;
    it.param_is_disperse_duty = is_duty;
    send_item(it);
  endtask

  // tick time: small steps, or aimed just short of / at or just past the end of an auto phase
  function automatic logic [NOW_W-1:0] pick_now();
    if (!in_cycle() || $urandom_range(0, 1) == 0)
      return mission_ms + NOW_W'($urandom_range(0, 1500));
    if ($urandom_range(0, 1) == 0)
      return pr_phase_start + span_ms() - 1'b1;
    return pr_phase_start + span_ms() + NOW_W'($urandom_range(0, 3));
  endfunction

  // mostly ticks with the link lost so the auto cycle runs deep, commands
  // rarer inside the cycle since any command ends it, a little pure noise
  task automatic send_random_item();
    item_t it;
    int roll;
    roll = int'($urandom_range(0, 99));
    if (roll < 4) begin
      it = base_item(1'($urandom_range(0, 1)));
      it.now_ms = NOW_W'({$urandom(), $urandom()});
    end else if (roll < (in_cycle() ? 12 : 40)) begin
      it = base_item(OP_COMMAND);
      it.now_ms = mission_ms + NOW_W'($urandom_range(0, 1500));
      // launch is the only way from standby to running, so favor it a bit
      if ($urandom_range(0, 4) == 0) it.command = CMD_LAUNCH;
      if ($urandom_range(0, 1) == 0) begin
        case (it.command)
          CMD_FIRE_VALVE: it.argument = 8'($urandom_range(VALVE_A, VALVE_B));
          CMD_MEMB_DUTY:  it.argument = 8'($urandom_range(0, DUTY_MAX));
          CMD_MOTOR:      it.argument = 8'($urandom_range(DISP_STOP, DISP_RUN));
          default: ;
        endcase
      end
    end else begin
      it = base_item(OP_TICK);
      it.now_ms    = pick_now();
      it.link_lost = ($urandom_range(0, 7) != 0);
    end
    mission_ms = it.now_ms;
    send_item(it);
  endtask

  // wait until every prediction has been matched and the pipe is empty
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // back-to-back writes of all four registers, only while idle
  task automatic write_registers(input logic [DUTY_W-1:0] duty, input logic [SEC_W-1:0] disp_s,
                                 input logic [SEC_W-1:0] memb_s, input logic [SEC_W-1:0] wait_s);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_AUTO_DUTY;
    cfg_data  <= CFG_W'(duty);
    @(posedge clk);
    cfg_index <= CFG_DISPERSE_S;
    cfg_data  <= disp_s;
    @(posedge clk);
    cfg_index <= CFG_MEMBRANE_S;
    cfg_data  <= memb_s;
    @(posedge clk);
    cfg_index <= CFG_WAIT_S;
    cfg_data  <= wait_s;
    @(posedge clk);
    cfg_we <= 1'b0;
    cf_auto_duty  = duty;
    cf_disperse_s = disp_s;
    cf_membrane_s = memb_s;
    cf_wait_s     = wait_s;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_power_up();
    item_t it;
    // first tick leaves init: standby or safe depending on the self test
    it = base_item(OP_TICK);
    it.now_ms = '0;
    send_item(it);
    send_cmd(CMD_UNDEFINED, 8'hFF);
    // start at wall time zero keeps the mission unstarted
    it = base_item(OP_COMMAND);
    it.command = CMD_LAUNCH;
    it.wall_s  = '0;
    send_item(it);
  endtask

  task automatic test_auto_cycle_edges();
    // link lost with no hold: enter disperse
    send_tick(1'b1, mission_ms + 10);
    // each phase: one ms short stays, exactly due moves on
    repeat (3) begin
      send_tick(1'b1, pr_phase_start + span_ms() - 1'b1);
      send_tick(1'b1, pr_phase_start + span_ms());
    end
    // link back: cycle left, back to running
    send_tick(1'b0, mission_ms + 5);
  endtask

  task automatic test_command_cases();
    send_cmd(CMD_FIRE_VALVE, NO_VALVE);   // bad valve number
    send_cmd(CMD_FIRE_VALVE, VALVE_A);    // fires with a pulse, motor idle
    send_cmd(CMD_FIRE_VALVE, VALVE_A);    // already fired: ok, nothing fires
    send_cmd(CMD_MOTOR, DISP_BAD);        // bad disperse mode
    send_cmd(CMD_MOTOR, DISP_RUN);
    send_cmd(CMD_FIRE_VALVE, VALVE_B);    // fires without pulse, motor held
    send_cmd(CMD_MOTOR, DISP_PULSE);      // pulse on a running motor: none
    send_param(1'b0, 1'($urandom_range(0, 1)));  // rejected parameter
    send_param(1'b1, 1'b1);               // speed change relatches the motor
    send_cmd(CMD_MEMB_DUTY, DUTY_OVER);   // duty out of range
    send_cmd(CMD_MEMB_DUTY, 8'(DUTY_MAX));
    send_cmd(CMD_MOTOR, DISP_STOP);
    send_cmd(CMD_TERMINATE, 8'($urandom_range(0, 255)));
    send_tick(1'($urandom_range(0, 1)), mission_ms + 10);  // termination closes valves
    send_cmd(CMD_MEMB_DUTY, 8'd0);        // manual drive wakes from safe
  endtask

  task automatic test_register_setting(input logic [DUTY_W-1:0] duty,
                                       input logic [SEC_W-1:0] disp_s,
                                       input logic [SEC_W-1:0] memb_s,
                                       input logic [SEC_W-1:0] wait_s);
    settle();
    write_registers(duty, disp_s, memb_s, wait_s);
    repeat (ITEMS_PER_SETTING) send_random_item();
  endtask

  // time base just below its top so phases start before and end after the wrap
  task automatic test_time_wrap();
    settle();
    write_registers(7'd60, 16'd1, 16'd2, 16'd1);
    mission_ms = '1 - NOW_W'(20000);
    repeat (ITEMS_PER_SETTING) send_random_item();
  endtask

  initial begin
    rst                    <= 1'b1;
    cfg_we                 <= 1'b0;
    cfg_index              <= CFG_AUTO_DUTY;
    cfg_data               <= '0;
    in_valid               <= 1'b0;
    op                     <= OP_TICK;
    now_ms                 <= '0;
    wall_s                 <= '0;
    link_lost              <= 1'b0;
    self_test_ok           <= 1'b0;
    command                <= CMD_ECHO;
    argument               <= '0;
    param_ok               <= 1'b0;
    param_is_disperse_duty <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_power_up();
    test_auto_cycle_edges();
    test_command_cases();

    // zero-length phases and a saturating duty
    test_register_setting(7'd127, 16'd0, 16'd0, 16'd0);
    // longest phases, zero duty
    test_register_setting(7'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // just above the duty limit, short phases
    test_register_setting(7'd101, 16'd1, 16'd2, 16'd3);
    test_time_wrap();
    test_register_setting(7'($urandom_range(0, 127)), 16'($urandom_range(0, 65535)),
                          16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    test_register_setting(AUTO_DUTY_RST, DISPERSE_S_RST, MEMBRANE_S_RST, WAIT_S_RST);

    settle();
    $display("ran %0d transactions under %0d register settings, %0d results compared",
             items_sent, settings_used, results_checked);
    $display("phases seen in results (bit per phase): %b, mismatches: %0d",
             phases_seen, fail_count);
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
design/msp_pkg.sv
design/mission_phase_sequencer.sv
verif/tb_mission_phase_sequencer.sv
